// File: hdl/rgb_to_yuv420_converter_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the RGB to YUV 4:2:0 converter
// Same-cycle and next-cycle implication checks on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef RGB_TO_YUV420_CONVERTER_CORE_MACROS_SVH
`define RGB_TO_YUV420_CONVERTER_CORE_MACROS_SVH

// ante implies cons in the same cycle
`define R2Y_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// ante implies cons in the next cycle
`define R2Y_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/r2y_pkg.sv
// ---------------------------------------------------------------------------
// RGB to YUV 4:2:0 converter package
// Register indexes, field widths and the BT.601 color arithmetic.
// ---------------------------------------------------------------------------
package r2y_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int ROW_W      = 12;
  localparam int ROW_LIMIT  = 4096;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [7:0]           comp_t;
  typedef logic [8:0]           pair_t;

  localparam cfg_idx_t REG_LINE_WIDTH = 2'd0;
  localparam cfg_idx_t REG_LINE_COUNT = 2'd1;

  localparam logic [CFG_DATA_W-1:0] LINE_WIDTH_RST = 13'd640;
  localparam logic [CFG_DATA_W-1:0] LINE_COUNT_RST = 13'd480;

  typedef struct packed {
    pair_t r;
    pair_t g;
    pair_t b;
  } pair_sum_t;

  function automatic comp_t luma_of(comp_t r, comp_t g, comp_t b);
    logic [15:0] acc;
    acc = 16'(16'(r) * 16'd66 + 16'(g) * 16'd129 + 16'(b) * 16'd25 + 16'd128);
    return comp_t'(acc[15:8] + 8'd16);
  endfunction

  function automatic comp_t cb_of(comp_t r, comp_t g, comp_t b);
    logic signed [15:0] v;
    v = 16'sd128 - 16'sd38 * signed'({8'b0, r}) - 16'sd74 * signed'({8'b0, g})
        + 16'sd112 * signed'({8'b0, b});
    return v[15:8] ^ 8'h80;
  endfunction

  function automatic comp_t cr_of(comp_t r, comp_t g, comp_t b);
    logic signed [15:0] v;
    v = 16'sd128 + 16'sd112 * signed'({8'b0, r}) - 16'sd94 * signed'({8'b0, g})
        - 16'sd18 * signed'({8'b0, b});
    return v[15:8] ^ 8'h80;
  endfunction

endpackage

// File: hdl/rgb_to_yuv420_converter_core.sv
// ---------------------------------------------------------------------------
// RGB to YUV 4:2:0 converter core
// BT.601 luma per pixel, 2x2 averaged chroma on each block's closing pixel;
// pair sums of even rows live in a line memory read back on odd rows.
// ---------------------------------------------------------------------------
//  channel | handshake             | payload
//  in      | in_valid / in_ready   | red, green, blue
//  out     | out_valid / out_ready | luma, chroma_valid, cb, cr, frame_end
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One pixel per cycle while out_ready allows; accept to result runs through
//  line memory read, 2x2 average and chroma products, each registered.
//  Each stage moves when the one after it is empty or moving, so bubbles
//  are squeezed out and input is taken while a result waits.
//  Synchronous reset clears position, held pixel and stage valids; the line
//  memory is not cleared. cfg is always ready.
// ---------------------------------------------------------------------------
`include "rgb_to_yuv420_converter_core_macros.svh"

module rgb_to_yuv420_converter_core
  import r2y_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  comp_t                 red,
  input  comp_t                 green,
  input  comp_t                 blue,
  output logic                  out_valid,
  input  logic                  out_ready,
  output comp_t                 luma,
  output logic                  chroma_valid,
  output comp_t                 cb,
  output comp_t                 cr,
  output logic                  frame_end
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int PD  = MAX_WIDTH / 2;
  localparam int AW  = (PD > 1) ? $clog2(PD) : 1;
  localparam int WCW = ($clog2(MAX_WIDTH + 1) > CFG_DATA_W) ? $clog2(MAX_WIDTH + 1)
                                                            : CFG_DATA_W;

  logic [CFG_DATA_W-1:0] line_width, line_count;
  logic [CW-1:0]         col_pos, col_pos_next;
  logic [ROW_W-1:0]      row_pos, row_pos_next;
  logic [23:0]           held_left;

  logic [WCW-1:0]        w_ext, w_eff, col_inc;
  logic [CFG_DATA_W-1:0] h_eff, row_inc;
  logic                  row_end, frame_done, col_odd, row_odd;
  logic                  in_fire, en_s1, en_s2, en_out;
  logic [AW-1:0]         slot;
  pair_sum_t             pair_now;

  pair_sum_t             pair_mem [PD];
  pair_sum_t             rd_q;

  logic                  s1_v, s1_blk, s1_fend;
  comp_t                 s1_r, s1_g, s1_b;
  pair_sum_t             s1_pair;

  logic                  s2_v, s2_blk, s2_fend;
  comp_t                 s2_luma, s2_ar, s2_ag, s2_ab;
  logic [9:0]            sum_r, sum_g, sum_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RST;
      line_count <= LINE_COUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LINE_WIDTH: line_width <= cfg_data;
        REG_LINE_COUNT: line_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en_out   = !out_valid || out_ready;
  assign en_s2    = !s2_v || en_out;
  assign en_s1    = !s1_v || en_s2;
  assign in_ready = en_s1;
  assign in_fire  = in_valid && in_ready;

  // position and frame bookkeeping
  always_comb begin
    w_ext = WCW'(line_width);
    if (w_ext == '0) begin
      w_eff = WCW'(1);
    end else if (w_ext > WCW'(MAX_WIDTH)) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (line_count == '0) begin
      h_eff = CFG_DATA_W'(1);
    end else if (line_count > CFG_DATA_W'(ROW_LIMIT)) begin
      h_eff = CFG_DATA_W'(ROW_LIMIT);
    end else begin
      h_eff = line_count;
    end
    col_inc    = WCW'(col_pos) + WCW'(1);
    row_inc    = CFG_DATA_W'(row_pos) + CFG_DATA_W'(1);
    row_end    = col_inc >= w_eff;
    frame_done = row_end && (row_inc >= h_eff);
    col_odd    = col_pos[0];
    row_odd    = row_pos[0];
    slot       = AW'(col_pos >> 1);
    pair_now.r = pair_t'(red)   + pair_t'(held_left[23:16]);
    pair_now.g = pair_t'(green) + pair_t'(held_left[15:8]);
    pair_now.b = pair_t'(blue)  + pair_t'(held_left[7:0]);
    if (!row_end) begin
      col_pos_next = CW'(col_inc);
      row_pos_next = row_pos;
    end else if (frame_done) begin
      col_pos_next = '0;
      row_pos_next = '0;
    end else begin
      col_pos_next = '0;
      row_pos_next = ROW_W'(row_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos   <= '0;
      row_pos   <= '0;
      held_left <= '0;
    end else if (in_fire) begin
      col_pos <= col_pos_next;
      row_pos <= row_pos_next;
      if (!col_odd) begin
        held_left <= {red, green, blue};
      end
    end
  end

  // line memory: write on even rows, read on every accepted pixel
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_q <= pair_mem[slot];
      if (col_odd && !row_odd) begin
        pair_mem[slot] <= pair_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en_s1) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r    <= red;
      s1_g    <= green;
      s1_b    <= blue;
      s1_pair <= pair_now;
      s1_blk  <= col_odd && row_odd;
      s1_fend <= frame_done;
    end
  end

  assign sum_r = 10'(s1_pair.r) + 10'(rd_q.r);
  assign sum_g = 10'(s1_pair.g) + 10'(rd_q.g);
  assign sum_b = 10'(s1_pair.b) + 10'(rd_q.b);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en_s2) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s2 && s1_v) begin
      s2_luma <= luma_of(s1_r, s1_g, s1_b);
      s2_ar   <= sum_r[9:2];
      s2_ag   <= sum_g[9:2];
      s2_ab   <= sum_b[9:2];
      s2_blk  <= s1_blk;
      s2_fend <= s1_fend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && s2_v) begin
      luma         <= s2_luma;
      chroma_valid <= s2_blk;
      cb           <= s2_blk ? cb_of(s2_ar, s2_ag, s2_ab) : '0;
      cr           <= s2_blk ? cr_of(s2_ar, s2_ag, s2_ab) : '0;
      frame_end    <= s2_fend;
    end
  end

  `R2Y_ASSERT_NEXT(a_frame_wrap, in_fire && frame_done, col_pos == '0 && row_pos == '0, "position did not wrap at frame end")
  `R2Y_ASSERT_NOW(a_col_bound, 1'b1, WCW'(col_pos) < WCW'(MAX_WIDTH), "column beyond maximum width")
  `R2Y_ASSERT_NOW(a_luma_range, out_valid, luma >= 8'd16 && luma <= 8'd235, "luma out of range")
  `R2Y_ASSERT_NOW(a_chroma_range, out_valid && chroma_valid, cb >= 8'd16 && cb <= 8'd240 && cr >= 8'd16 && cr <= 8'd240, "chroma out of range")

endmodule
